/* rtl/bpa_pkg.sv */
// Shared types and codes for the buddy page allocator.
// Depends on nothing; used by buddy_page_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // Order code stored in frames that are not block heads
  localparam logic [3:0] NO_ORDER = 4'hF;

  // Per-frame status
  typedef enum logic [1:0] {
    FS_FREE = 2'd0,
    FS_USED = 2'd1,
    FS_CONT = 2'd2
  } frame_st_e;

  // Result status codes
  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_TOO_LARGE = 2'd1,
    RS_NO_MEM    = 2'd2,
    RS_BAD_ADDR  = 2'd3
  } resp_e;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_A_RD,
    S_A_SPLIT,
    S_A_WL,
    S_A_WR,
    S_A_WH,
    S_A_GRD,
    S_A_GN,
    S_A_GB,
    S_F_DIV,
    S_F_REM,
    S_F_CHK,
    S_M_TEST,
    S_M_CHK,
    S_M_WP,
    S_M_WN,
    S_M_WB,
    S_M_WF,
    S_F_WF,
    S_F_WH,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* rtl/buddy_page_allocator_core.sv */
// Buddy page allocator: frame table memory, list heads and sequencer.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | operation, request_bytes, block_address
// out     | output    | out_valid_o / out_stall_i | status, granted_address, final_order
// config  | input     | APB psel/penable/pwrite   | memory_base at address 0
//
// One item at a time. Allocate: accept, per split read, split and write both
// halves and the old head, grant (read, unlink, mark used), post. Free: accept,
// find the frame number, check the frame, per merge test and unlink the buddy
// and rewrite both, test the last buddy, push back, post. Rejected items end early.
// After reset a clearing pass over all frames sets up the frame table; no
// item is taken during it. A stalled result holds the sequencer in its
// final state until the result register frees.

module buddy_page_allocator_core #(
  parameter int FRAME_COUNT = 256,
  parameter int MAX_ORDER   = 3,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] request_bytes_i,
  input  wire logic [31:0] block_address_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      granted_address_o,
  output logic [3:0]       final_order_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW   = $clog2(FRAME_COUNT);     // frame index bits
  localparam int LW   = $clog2(FRAME_COUNT + 1); // link bits, holds null
  localparam int KW   = $clog2(MAX_ORDER + 1);   // list head index bits
  localparam int TOP  = 1 << MAX_ORDER;
  localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);
  localparam longint LIMIT = longint'(PAGE_BYTES) * longint'(FRAME_COUNT);
  localparam logic [31:0] PAGE_W = 32'(PAGE_BYTES);
  // Reciprocal of the page size, exact for any 32-bit offset
  localparam int PSH = $clog2(PAGE_BYTES);
  localparam int RSH = 32 + PSH;
  localparam logic [32:0] RECIP =
    33'(((longint'(1) << RSH) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES));

  typedef struct packed {
    logic [3:0]         ord;
    bpa_pkg::frame_st_e st;
    logic [LW-1:0]      nxt;
    logic [LW-1:0]      prv;
  } ent_t;

  typedef struct packed {
    logic ord;
    logic st;
    logic nxt;
    logic prv;
  } ent_we_t;

  // Frame table
  ent_t          mem [FRAME_COUNT];
  ent_t          rdata_q;
  logic          re;
  logic [AW-1:0] ra;
  ent_we_t       we;
  logic [AW-1:0] wa;
  ent_t          wd;

  bpa_pkg::state_e state_q, state_d;
  logic [3:0]    k_q, k_d, need_q, need_d;
  logic [LW-1:0] f_q, f_d, b_q, b_d, left_q, left_d;
  logic [LW-1:0] n_q, n_d, p_q, p_d, h_q, h_d, clr_q, clr_d;
  logic [31:0]   rem_q, rem_d;
  logic [LW-1:0] head_q [MAX_ORDER+1];
  logic [LW-1:0] head_d [MAX_ORDER+1];
  logic [31:0]   base_q;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d, res_st_q, res_st_d;
  logic [31:0]   addr_q, addr_d, res_addr_q, res_addr_d;
  logic [3:0]    ord_q, ord_d, res_ord_q, res_ord_d;

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (we.ord) mem[wa].ord <= wd.ord;
    if (we.st)  mem[wa].st  <= wd.st;
    if (we.nxt) mem[wa].nxt <= wd.nxt;
    if (we.prv) mem[wa].prv <= wd.prv;
    if (re) rdata_q <= mem[ra];
  end

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      base_q <= pwdata;
    end
  end

  // Request decode helpers
  logic [MAX_ORDER:0] fits;
  logic [3:0]         need_c, found_c;
  logic               found_ok;
  logic [31:0]        off_c;
  logic [31:0]        bx_c;
  logic [31:0]        ci;
  logic [LW-1:0]      kbit;
  logic [KW-1:0]      km1_c;
  logic [64:0]        quot_c;

  always_comb begin
    fits     = '0;
    need_c   = 4'd0;
    found_c  = 4'd0;
    found_ok = 1'b0;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      fits[i] = ({1'b0, request_bytes_i} <= 33'(longint'(PAGE_BYTES) << i));
    end
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (fits[i]) need_c = 4'(i);
    end
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ((4'(i) >= need_c) && (head_q[i] != NIL)) begin
        found_c  = 4'(i);
        found_ok = 1'b1;
      end
    end
  end

  assign off_c  = block_address_i - base_q;
  assign bx_c   = 32'(f_q) ^ (32'd1 << k_q);
  assign ci     = 32'(clr_q);
  assign kbit   = (k_q == 4'd0) ? LW'(0) : LW'(32'd1 << (k_q - 4'd1));
  assign km1_c  = KW'(k_q - 4'd1);
  assign quot_c = {33'd0, rem_q} * {32'd0, RECIP};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    need_d     = need_q;
    f_d        = f_q;
    b_d        = b_q;
    left_d     = left_q;
    n_d        = n_q;
    p_d        = p_q;
    h_d        = h_q;
    clr_d      = clr_q;
    rem_d      = rem_q;
    head_d     = head_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_ord_d  = res_ord_q;
    re         = 1'b0;
    ra         = '0;
    we         = '0;
    wa         = '0;
    wd         = '{ord: bpa_pkg::NO_ORDER, st: bpa_pkg::FS_CONT, nxt: NIL, prv: NIL};
    in_stall_o = 1'b1;

    case (state_q)
      // Reset pass: chain whole top blocks in ascending order
      bpa_pkg::S_CLR: begin
        we = '{ord: 1'b1, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa = clr_q[AW-1:0];
        if (((ci & 32'(TOP - 1)) == 32'd0) && (ci + 32'(TOP) <= 32'(FRAME_COUNT))) begin
          wd.ord = 4'(MAX_ORDER);
          wd.st  = bpa_pkg::FS_FREE;
          wd.nxt = (ci + 32'(2 * TOP) <= 32'(FRAME_COUNT)) ? LW'(ci + 32'(TOP)) : NIL;
          wd.prv = (ci == 32'd0) ? NIL : LW'(ci - 32'(TOP));
        end
        clr_d = clr_q + LW'(1);
        if (clr_q == LW'(FRAME_COUNT - 1)) state_d = bpa_pkg::S_IDLE;
      end

      bpa_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        res_addr_d = 32'd0;
        res_ord_d  = 4'd0;
        if (in_valid_i) begin
          if (!operation_i) begin
            need_d = need_c;
            k_d    = found_c;
            if (!fits[MAX_ORDER]) begin
              res_st_d = bpa_pkg::RS_TOO_LARGE;
              state_d  = bpa_pkg::S_DONE;
            end else if (!found_ok) begin
              res_st_d = bpa_pkg::RS_NO_MEM;
              state_d  = bpa_pkg::S_DONE;
            end else if (found_c > need_c) begin
              state_d = bpa_pkg::S_A_RD;
            end else begin
              state_d = bpa_pkg::S_A_GRD;
            end
          end else begin
            if ((block_address_i < base_q) || ({32'd0, off_c} >= 64'(LIMIT))) begin
              res_st_d = bpa_pkg::RS_BAD_ADDR;
              state_d  = bpa_pkg::S_DONE;
            end else begin
              rem_d   = off_c;
              state_d = bpa_pkg::S_F_DIV;
            end
          end
        end
      end

      // Split: take the head block of order k
      bpa_pkg::S_A_RD: begin
        re      = 1'b1;
        ra      = head_q[k_q[KW-1:0]][AW-1:0];
        left_d  = head_q[k_q[KW-1:0]];
        state_d = bpa_pkg::S_A_SPLIT;
      end

      bpa_pkg::S_A_SPLIT: begin
        we.prv = (rdata_q.nxt != NIL);
        wa     = rdata_q.nxt[AW-1:0];
        wd.prv = NIL;
        head_d[k_q[KW-1:0]] = rdata_q.nxt;
        head_d[km1_c]       = left_q;
        h_d     = head_q[km1_c];
        b_d     = left_q + kbit;
        k_d     = k_q - 4'd1;
        state_d = bpa_pkg::S_A_WL;
      end

      bpa_pkg::S_A_WL: begin
        we      = '{ord: 1'b1, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa      = left_q[AW-1:0];
        wd      = '{ord: k_q, st: bpa_pkg::FS_FREE, nxt: b_q, prv: NIL};
        state_d = bpa_pkg::S_A_WR;
      end

      bpa_pkg::S_A_WR: begin
        we      = '{ord: 1'b1, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa      = b_q[AW-1:0];
        wd      = '{ord: k_q, st: bpa_pkg::FS_FREE, nxt: h_q, prv: left_q};
        state_d = bpa_pkg::S_A_WH;
      end

      bpa_pkg::S_A_WH: begin
        we.prv  = (h_q != NIL);
        wa      = h_q[AW-1:0];
        wd.prv  = b_q;
        state_d = (k_q > need_q) ? bpa_pkg::S_A_RD : bpa_pkg::S_A_GRD;
      end

      // Grant: unlink the head block of the needed order
      bpa_pkg::S_A_GRD: begin
        re      = 1'b1;
        ra      = head_q[need_q[KW-1:0]][AW-1:0];
        left_d  = head_q[need_q[KW-1:0]];
        state_d = bpa_pkg::S_A_GN;
      end

      bpa_pkg::S_A_GN: begin
        we.prv  = (rdata_q.nxt != NIL);
        wa      = rdata_q.nxt[AW-1:0];
        wd.prv  = NIL;
        head_d[need_q[KW-1:0]] = rdata_q.nxt;
        state_d = bpa_pkg::S_A_GB;
      end

      bpa_pkg::S_A_GB: begin
        we         = '{ord: 1'b0, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa         = left_q[AW-1:0];
        wd.st      = bpa_pkg::FS_USED;
        res_st_d   = bpa_pkg::RS_OK;
        res_addr_d = base_q + 32'(left_q) * PAGE_W;
        res_ord_d  = need_q;
        state_d    = bpa_pkg::S_DONE;
      end

      // Frame number by reciprocal multiply
      bpa_pkg::S_F_DIV: begin
        f_d     = LW'(quot_c[RSH +: AW]);
        state_d = bpa_pkg::S_F_REM;
      end

      // Offset must be an exact page multiple
      bpa_pkg::S_F_REM: begin
        if (rem_q != 32'(f_q) * PAGE_W) begin
          res_st_d = bpa_pkg::RS_BAD_ADDR;
          state_d  = bpa_pkg::S_DONE;
        end else begin
          re      = 1'b1;
          ra      = f_q[AW-1:0];
          state_d = bpa_pkg::S_F_CHK;
        end
      end

      bpa_pkg::S_F_CHK: begin
        if ((rdata_q.st != bpa_pkg::FS_USED) || (rdata_q.ord > 4'(MAX_ORDER))) begin
          res_st_d = bpa_pkg::RS_BAD_ADDR;
          state_d  = bpa_pkg::S_DONE;
        end else begin
          k_d     = rdata_q.ord;
          state_d = bpa_pkg::S_M_TEST;
        end
      end

      // Merge: look at the buddy of the current block
      bpa_pkg::S_M_TEST: begin
        if ((k_q < 4'(MAX_ORDER)) && (bx_c < 32'(FRAME_COUNT))) begin
          re      = 1'b1;
          ra      = bx_c[AW-1:0];
          b_d     = LW'(bx_c);
          state_d = bpa_pkg::S_M_CHK;
        end else begin
          state_d = bpa_pkg::S_F_WF;
        end
      end

      bpa_pkg::S_M_CHK: begin
        if ((rdata_q.st == bpa_pkg::FS_FREE) && (rdata_q.ord == k_q)) begin
          p_d     = rdata_q.prv;
          n_d     = rdata_q.nxt;
          state_d = bpa_pkg::S_M_WP;
        end else begin
          state_d = bpa_pkg::S_F_WF;
        end
      end

      bpa_pkg::S_M_WP: begin
        if (p_q != NIL) begin
          we.nxt = 1'b1;
          wa     = p_q[AW-1:0];
          wd.nxt = n_q;
        end else begin
          head_d[k_q[KW-1:0]] = n_q;
        end
        state_d = bpa_pkg::S_M_WN;
      end

      bpa_pkg::S_M_WN: begin
        we.prv  = (n_q != NIL);
        wa      = n_q[AW-1:0];
        wd.prv  = p_q;
        state_d = bpa_pkg::S_M_WB;
      end

      bpa_pkg::S_M_WB: begin
        we      = '{ord: 1'b1, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa      = b_q[AW-1:0];
        state_d = bpa_pkg::S_M_WF;
      end

      bpa_pkg::S_M_WF: begin
        we      = '{ord: 1'b1, st: 1'b1, nxt: 1'b0, prv: 1'b0};
        wa      = f_q[AW-1:0];
        f_d     = (b_q < f_q) ? b_q : f_q;
        k_d     = k_q + 4'd1;
        state_d = bpa_pkg::S_M_TEST;
      end

      // Push the merged block on its list
      bpa_pkg::S_F_WF: begin
        we      = '{ord: 1'b1, st: 1'b1, nxt: 1'b1, prv: 1'b1};
        wa      = f_q[AW-1:0];
        wd      = '{ord: k_q, st: bpa_pkg::FS_FREE, nxt: head_q[k_q[KW-1:0]], prv: NIL};
        h_d     = head_q[k_q[KW-1:0]];
        head_d[k_q[KW-1:0]] = f_q;
        state_d = bpa_pkg::S_F_WH;
      end

      bpa_pkg::S_F_WH: begin
        we.prv    = (h_q != NIL);
        wa        = h_q[AW-1:0];
        wd.prv    = f_q;
        res_st_d  = bpa_pkg::RS_OK;
        res_ord_d = k_q;
        state_d   = bpa_pkg::S_DONE;
      end

      bpa_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = bpa_pkg::S_IDLE;
      end

      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    addr_d      = addr_q;
    ord_d       = ord_q;
    if ((state_q == bpa_pkg::S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      status_d    = res_st_q;
      addr_d      = res_addr_q;
      ord_d       = res_ord_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign granted_address_o = addr_q;
  assign final_order_o     = ord_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        head_q[i] <= ((i == MAX_ORDER) && (FRAME_COUNT >= TOP)) ? LW'(0) : NIL;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    need_q     <= need_d;
    f_q        <= f_d;
    b_q        <= b_d;
    left_q     <= left_d;
    n_q        <= n_d;
    p_q        <= p_d;
    h_q        <= h_d;
    rem_q      <= rem_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_ord_q  <= res_ord_d;
    status_q   <= status_d;
    addr_q     <= addr_d;
    ord_q      <= ord_d;
  end

endmodule

`default_nettype wire
